/* hdl/sdseq_pkg.sv */
// Shared types and constants for the package dispense sequencer.
`timescale 1ns / 1ps

package sdseq_pkg;

    // Input operation codes
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_TRIGGER = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_RELOAD  = 3'd3,
        OP_STOP    = 3'd4
    } op_t;

    // Drop sequencer phases, one-hot internally
    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_MOVING    = 4'b0010,
        PH_WORKING   = 4'b0100,
        PH_RETURNING = 4'b1000
    } phase_t;

    // Phase codes as reported on the result
    localparam logic [1:0] PHASE_CODE_IDLE      = 2'd0;
    localparam logic [1:0] PHASE_CODE_MOVING    = 2'd1;
    localparam logic [1:0] PHASE_CODE_WORKING   = 2'd2;
    localparam logic [1:0] PHASE_CODE_RETURNING = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_STANDBY_ANGLE  = 2'd0;
    localparam logic [1:0] CFG_WORKING_OFFSET = 2'd1;
    localparam logic [1:0] CFG_MOVE_TIME      = 2'd2;
    localparam logic [1:0] CFG_DWELL_TIME     = 2'd3;

    localparam logic [15:0] MOVE_TIME_RESET  = 16'd500;
    localparam logic [15:0] DWELL_TIME_RESET = 16'd500;
    localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;
    localparam logic [7:0]  PENDING_MAX      = 8'hFF;

    typedef struct packed {
        logic [7:0]        standby_angle;
        logic signed [7:0] working_offset;
        logic [15:0]       move_time_ms;
        logic [15:0]       dwell_time_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [9:0] servo_angle;
        logic [1:0]        phase;
        logic [7:0]        packages_left;
        logic [7:0]        pending_drops;
        logic              busy_res;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        begin
            unique case (ph)
                PH_IDLE:      code = PHASE_CODE_IDLE;
                PH_MOVING:    code = PHASE_CODE_MOVING;
                PH_WORKING:   code = PHASE_CODE_WORKING;
                PH_RETURNING: code = PHASE_CODE_RETURNING;
                default:      code = PHASE_CODE_IDLE;
            endcase
            return code;
        end
    endfunction

endpackage

/* hdl/sdseq_cfg_regs.sv */
// Configuration register bank: angles and phase durations.
`timescale 1ns / 1ps

module sdseq_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output sdseq_pkg::cfg_t      cfg
);

    sdseq_pkg::cfg_t cfg_reg;
    logic            wr_en;

    // Writes are always accepted
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.standby_angle  <= 8'd0;
            cfg_reg.working_offset <= 8'sd0;
            cfg_reg.move_time_ms   <= sdseq_pkg::MOVE_TIME_RESET;
            cfg_reg.dwell_time_ms  <= sdseq_pkg::DWELL_TIME_RESET;
        end
        else if (wr_en)
        begin
            unique case (cfg_index)
                sdseq_pkg::CFG_STANDBY_ANGLE:  cfg_reg.standby_angle  <= cfg_data[7:0];
                sdseq_pkg::CFG_WORKING_OFFSET: cfg_reg.working_offset <= cfg_data[7:0];
                sdseq_pkg::CFG_MOVE_TIME:      cfg_reg.move_time_ms   <= cfg_data;
                sdseq_pkg::CFG_DWELL_TIME:     cfg_reg.dwell_time_ms  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* hdl/sdseq_core.sv */
// Sequencer state registers and the per-transfer update logic.
`timescale 1ns / 1ps

module sdseq_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_accept,
    input  logic [2:0]           operation,
    input  logic [7:0]           argument,
    input  sdseq_pkg::cfg_t      cfg,
    output sdseq_pkg::result_t   result
);

    sdseq_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        pending_reg, pending_next;
    logic [7:0]        packages_reg, packages_next;
    logic              clear_mode_reg, clear_mode_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic              at_working_reg, at_working_next;

    logic [15:0]       elapsed_inc;
    logic [7:0]        trig_add;
    logic [8:0]        trig_sum;
    logic signed [9:0] offset_ext;

    assign elapsed_inc = (elapsed_reg == sdseq_pkg::ELAPSED_MAX) ?
                         elapsed_reg : elapsed_reg + 16'd1;
    assign trig_add    = (argument > packages_reg) ? packages_reg : argument;
    assign trig_sum    = {1'b0, pending_reg} + {1'b0, trig_add};

    always_comb
    begin
        phase_next      = phase_reg;
        pending_next    = pending_reg;
        packages_next   = packages_reg;
        clear_mode_next = clear_mode_reg;
        elapsed_next    = elapsed_reg;
        at_working_next = at_working_reg;

        unique case (sdseq_pkg::op_t'(operation))
            sdseq_pkg::OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                unique case (phase_reg)
                    sdseq_pkg::PH_IDLE:
                    begin
                        if (pending_reg != 8'd0)
                        begin
                            phase_next   = sdseq_pkg::PH_MOVING;
                            elapsed_next = 16'd0;
                        end
                        else if (clear_mode_reg && (packages_reg != 8'd0))
                        begin
                            pending_next = 8'd1;
                        end
                        else if (clear_mode_reg)
                        begin
                            clear_mode_next = 1'b0;
                        end
                    end
                    sdseq_pkg::PH_MOVING:
                    begin
                        if (elapsed_inc >= cfg.move_time_ms)
                        begin
                            at_working_next = 1'b1;
                            phase_next      = sdseq_pkg::PH_WORKING;
                            elapsed_next    = 16'd0;
                            if (packages_reg != 8'd0)
                                packages_next = packages_reg - 8'd1;
                            if (pending_reg != 8'd0)
                                pending_next = pending_reg - 8'd1;
                        end
                    end
                    sdseq_pkg::PH_WORKING:
                    begin
                        if (elapsed_inc >= cfg.dwell_time_ms)
                        begin
                            at_working_next = 1'b0;
                            phase_next      = sdseq_pkg::PH_RETURNING;
                            elapsed_next    = 16'd0;
                        end
                    end
                    sdseq_pkg::PH_RETURNING:
                    begin
                        if (elapsed_inc >= cfg.move_time_ms)
                        begin
                            phase_next   = sdseq_pkg::PH_IDLE;
                            elapsed_next = 16'd0;
                        end
                    end
                    default: ;
                endcase
            end
            sdseq_pkg::OP_TRIGGER:
            begin
                if (packages_reg != 8'd0)
                    pending_next = trig_sum[8] ? sdseq_pkg::PENDING_MAX : trig_sum[7:0];
            end
            sdseq_pkg::OP_CLEAR:
            begin
                clear_mode_next = 1'b1;
            end
            sdseq_pkg::OP_RELOAD:
            begin
                packages_next = argument;
            end
            sdseq_pkg::OP_STOP:
            begin
                at_working_next = 1'b0;
                phase_next      = sdseq_pkg::PH_IDLE;
                pending_next    = 8'd0;
                clear_mode_next = 1'b0;
                elapsed_next    = 16'd0;
            end
            default: ;  // unused codes leave the state alone
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sdseq_pkg::PH_IDLE;
            pending_reg    <= 8'd0;
            packages_reg   <= 8'd0;
            clear_mode_reg <= 1'b0;
            elapsed_reg    <= 16'd0;
            at_working_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            pending_reg    <= pending_next;
            packages_reg   <= packages_next;
            clear_mode_reg <= clear_mode_next;
            elapsed_reg    <= elapsed_next;
            at_working_reg <= at_working_next;
        end
    end

    // Result reflects the state after this transfer
    assign offset_ext = at_working_next ?
                        {{2{cfg.working_offset[7]}}, cfg.working_offset} : 10'sd0;

    always_comb
    begin
        result.servo_angle   = $signed({2'b00, cfg.standby_angle}) + offset_ext;
        result.phase         = sdseq_pkg::phase_code(phase_next);
        result.packages_left = packages_next;
        result.pending_drops = pending_next;
        result.busy_res      = (phase_next != sdseq_pkg::PH_IDLE) || (pending_next != 8'd0);
    end

endmodule

/* hdl/sdseq_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module sdseq_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sdseq_pkg::result_t   push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sdseq_pkg::result_t   out_data
);

    logic               main_valid_reg;
    logic               skid_valid_reg;
    sdseq_pkg::result_t main_reg;
    sdseq_pkg::result_t skid_reg;
    logic               pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

endmodule

/* hdl/servo_package_dispense_sequencer_top.sv */
// Top level of the servo package dispense sequencer.
`timescale 1ns / 1ps

// Servo package dispense sequencer. Each input transfer carries one operation
// (1 ms tick, trigger(count), clear-all, reload(amount), stop) and produces
// exactly one result transfer reporting the commanded servo angle, phase,
// packages left, pending drops and a busy flag after that operation. The
// block takes one input transfer per clock while in_stall is low: the state
// update is a single pass of short logic (a 16-bit saturating increment and
// compare against the phase duration) from the state registers into the
// result register. A two-entry result buffer lets one more input transfer in
// while a result is stalled; in_stall rises only when both entries are full.
// Configuration writes are always accepted (cfg_ready is always high) and
// must only be issued while no results are outstanding.

module servo_package_dispense_sequencer_top (
    input  logic              clk,
    input  logic              rst_n,

    // input item channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        operation,
    input  logic [7:0]        argument,

    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [9:0] servo_angle,
    output logic [1:0]        phase,
    output logic [7:0]        packages_left,
    output logic [7:0]        pending_drops,
    output logic              busy_res,

    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    sdseq_pkg::cfg_t    cfg;
    sdseq_pkg::result_t core_result;
    sdseq_pkg::result_t out_data;
    logic               in_accept;
    logic               buf_full;

    // A transfer is taken whenever the skid entry is free
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !in_stall;

    sdseq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdseq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .operation (operation),
        .argument  (argument),
        .cfg       (cfg),
        .result    (core_result)
    );

    sdseq_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign servo_angle   = out_data.servo_angle;
    assign phase         = out_data.phase;
    assign packages_left = out_data.packages_left;
    assign pending_drops = out_data.pending_drops;
    assign busy_res      = out_data.busy_res;

    // Skid entry can only be occupied behind a valid output entry
    a_stall_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result held");

    // Skid entry only fills when the output was held off
    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("skid entry filled without output stall");

    // Busy flag agrees with reported phase and queue
    a_busy_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (busy_res == ((phase != sdseq_pkg::PHASE_CODE_IDLE) ||
                                    (pending_drops != 8'd0))))
        else $error("busy flag inconsistent with phase and pending drops");

endmodule
